@@ rtl/core/deque_with_indexed_removal_defines.svh @@
// assertion macros for the deque with indexed removal
// expects clk and rst_n in the scope where a macro is used
`ifndef DEQUE_WITH_INDEXED_REMOVAL_DEFINES_SVH
`define DEQUE_WITH_INDEXED_REMOVAL_DEFINES_SVH

`ifndef SYNTHESIS
`define DQIR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dqir assertion failed");
`define DQIR_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("dqir forbidden condition seen");
`else
`define DQIR_ASSERT(lbl, prop)
`define DQIR_NEVER(lbl, expr)
`endif

`endif

@@ rtl/core/dqir_pkg.sv @@
// types and constants of the deque with indexed removal
// no dependencies; imported by the top level
package dqir_pkg;

    localparam int DEPTH    = 16;   // power of two, slot arithmetic wraps by truncation
    localparam int DATA_W   = 32;
    localparam int SLOT_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int CMD_W    = 3;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;

    localparam int IN_FIELDS_W  = CMD_W + DATA_W + POS_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = DATA_W + STATUS_W + CNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_REMOVE_AT  = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ_WAIT,
        S_MOVE,
        S_REPLY
    } state_t;

endpackage

@@ rtl/core/deque_with_indexed_removal.sv @@
// a command is registered when accepted and decoded in S_DECODE; a pop or a removal
// reads its target word in S_READ_WAIT, a removal then shifts later entries down in
// S_MOVE, and S_REPLY loads the result beat; a new command is taken only in S_IDLE;
// the entry store has one write and one read port, so closing the gap after a removal
// moves one entry per cycle; reset clears the front slot, the count and the handshake
// state; store contents stay unknown until written and only live entries are ever read
`include "deque_with_indexed_removal_defines.svh"

module deque_with_indexed_removal
    import dqir_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // command [2:0], data_in [34:3], position [42:35], zero padding above
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // data_out [31:0], status [33:32], occupancy_out [38:34], zero padding above
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [DATA_W-1:0] entry_mem [DEPTH];

    state_t state_reg, state_next;

    logic [SLOT_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0]  occupancy_reg, occupancy_next;
    logic              m_tvalid_reg, m_tvalid_next;

    logic [CMD_W-1:0]       cmd_reg;
    logic [DATA_W-1:0]      data_in_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [SLOT_W-1:0]      idx_reg, idx_next;
    logic [DATA_W-1:0]      word_reg, word_next;
    status_t                status_reg, status_next;
    logic [OUT_TDATA_W-1:0] m_data_reg;

    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data_reg;

    logic              in_beat;
    logic              out_free;
    logic              is_full;
    logic              is_empty;
    logic              decode_reads;
    logic [CNT_W-1:0]  next_src;
    logic              more_moves;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_tvalid_reg || m_axis_tready;
    assign is_full  = (occupancy_reg == CNT_W'(DEPTH));
    assign is_empty = (occupancy_reg == '0);

    // pops and in-range removals need the target word from the store
    always_comb
    begin
        case (cmd_t'(cmd_reg))
            CMD_POP_FRONT, CMD_POP_BACK: decode_reads = !is_empty;
            CMD_REMOVE_AT:               decode_reads = (pos_reg < POS_W'(occupancy_reg));
            default:                     decode_reads = 1'b0;
        endcase
    end

    // logical index of the next entry to shift down
    assign next_src   = (state_reg == S_MOVE) ? CNT_W'(idx_reg) + CNT_W'(2)
                                              : CNT_W'(idx_reg) + CNT_W'(1);
    assign more_moves = (next_src < occupancy_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                state_next = decode_reads ? S_READ_WAIT : S_REPLY;
            end
            S_READ_WAIT:
            begin
                if (cmd_t'(cmd_reg) == CMD_REMOVE_AT && more_moves)
                    state_next = S_MOVE;
                else
                    state_next = S_REPLY;
            end
            S_MOVE:
            begin
                if (!more_moves)
                    state_next = S_REPLY;
            end
            S_REPLY:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and store access
    always_comb
    begin
        front_next     = front_reg;
        occupancy_next = occupancy_reg;
        idx_next       = idx_reg;
        word_next      = word_reg;
        status_next    = status_reg;
        m_tvalid_next  = m_tvalid_reg && !m_axis_tready;
        wr_en          = 1'b0;
        wr_addr        = front_reg;
        wr_data        = data_in_reg;
        rd_en          = 1'b0;
        rd_addr        = front_reg + next_src[SLOT_W-1:0];
        s_axis_tready  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            S_DECODE:
            begin
                word_next   = '0;
                status_next = ST_OK;
                case (cmd_t'(cmd_reg))
                    CMD_PUSH_FRONT:
                    begin
                        if (is_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            wr_en          = 1'b1;
                            wr_addr        = front_reg - SLOT_W'(1);
                            front_next     = front_reg - SLOT_W'(1);
                            occupancy_next = occupancy_reg + CNT_W'(1);
                        end
                    end
                    CMD_PUSH_BACK:
                    begin
                        if (is_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            wr_en          = 1'b1;
                            wr_addr        = front_reg + occupancy_reg[SLOT_W-1:0];
                            occupancy_next = occupancy_reg + CNT_W'(1);
                        end
                    end
                    CMD_POP_FRONT:
                    begin
                        if (is_empty)
                            status_next = ST_EMPTY;
                        else
                        begin
                            rd_en   = 1'b1;
                            rd_addr = front_reg;
                        end
                    end
                    CMD_POP_BACK:
                    begin
                        if (is_empty)
                            status_next = ST_EMPTY;
                        else
                        begin
                            rd_en   = 1'b1;
                            rd_addr = front_reg + occupancy_reg[SLOT_W-1:0] - SLOT_W'(1);
                        end
                    end
                    CMD_REMOVE_AT:
                    begin
                        if (!decode_reads)
                            status_next = ST_EMPTY;
                        else
                        begin
                            rd_en    = 1'b1;
                            rd_addr  = front_reg + pos_reg[SLOT_W-1:0];
                            idx_next = pos_reg[SLOT_W-1:0];
                        end
                    end
                    default:
                    begin
                        status_next = ST_EMPTY;
                    end
                endcase
            end
            S_READ_WAIT:
            begin
                word_next = rd_data_reg;
                case (cmd_t'(cmd_reg))
                    CMD_POP_FRONT:
                    begin
                        front_next     = front_reg + SLOT_W'(1);
                        occupancy_next = occupancy_reg - CNT_W'(1);
                    end
                    CMD_REMOVE_AT:
                    begin
                        // fetch the successor of the removed entry, if any
                        if (more_moves)
                            rd_en = 1'b1;
                        else
                            occupancy_next = occupancy_reg - CNT_W'(1);
                    end
                    default:
                    begin
                        occupancy_next = occupancy_reg - CNT_W'(1);
                    end
                endcase
            end
            S_MOVE:
            begin
                // write entry idx+1 into slot idx while idx+2, if any, is being read
                wr_en    = 1'b1;
                wr_addr  = front_reg + idx_reg;
                wr_data  = rd_data_reg;
                idx_next = idx_reg + SLOT_W'(1);
                if (more_moves)
                    rd_en = 1'b1;
                else
                    occupancy_next = occupancy_reg - CNT_W'(1);
            end
            S_REPLY:
            begin
                if (out_free)
                    m_tvalid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            occupancy_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            occupancy_reg <= occupancy_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            cmd_reg     <= s_axis_tdata[CMD_W-1:0];
            data_in_reg <= s_axis_tdata[CMD_W +: DATA_W];
            pos_reg     <= s_axis_tdata[CMD_W+DATA_W +: POS_W];
        end
        idx_reg    <= idx_next;
        word_reg   <= word_next;
        status_reg <= status_next;
        if (state_reg == S_REPLY && out_free)
            m_data_reg <= OUT_TDATA_W'({occupancy_reg, status_reg, word_reg});
    end

    // entry store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= entry_mem[rd_addr];
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_data_reg;

    `DQIR_NEVER(a_occupancy_range, occupancy_reg > CNT_W'(DEPTH))
    `DQIR_ASSERT(a_accept_starts_decode, in_beat |=> state_reg == S_DECODE)
    `DQIR_ASSERT(a_reply_loads_output,
        (state_reg == S_REPLY && out_free) |=> (m_tvalid_reg && state_reg == S_IDLE))
    `DQIR_NEVER(a_no_same_slot_access, wr_en && rd_en && wr_addr == rd_addr)

endmodule
